// File: rtl/core/mas_pkg.sv
// Shared constants, types and helpers of the matrix add/subtract/multiply engine.
// No dependencies; used by mas_store and matrix_add_sub_multiply.
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

   localparam int MAX_DIM     = 8;
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int DATA_W      = 16;
   localparam int DIM_W       = 4;
   localparam int TERM_W      = 2 * DATA_W;
   localparam int VALUE_W     = 40;
   localparam int OP_W        = 3;
   localparam int CSR_IDX_W   = 2;

   localparam logic [OP_W-1:0] OP_LOAD_A = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 3'd1;
   localparam logic [OP_W-1:0] OP_SUM    = 3'd2;
   localparam logic [OP_W-1:0] OP_DIFF   = 3'd3;
   localparam logic [OP_W-1:0] OP_PROD   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B    = 2'd2;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } store_wr_type;

   // zero counts as one, anything above MAX_DIM as MAX_DIM
   function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] reg_val);
      logic [DIM_W-1:0] dim;
      dim = reg_val;
      if (reg_val == '0) begin
         dim = DIM_W'(1);
      end else if (reg_val > DIM_W'(MAX_DIM)) begin
         dim = DIM_W'(MAX_DIM);
      end
      return dim;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/mas_store.sv
// One matrix store: synchronous RAM with one write and one read port, registered read data.
// Per-entry valid bits make never-written entries read as zero. Depends on mas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mas_store
   import mas_pkg::*;
(
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  store_wr_type      wr,
   input  wire  logic [ADDR_W-1:0] rd_addr,
   output logic       [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0]      mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] valid_ff;
   logic [DATA_W-1:0]      rd_raw_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_raw_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

`default_nettype wire

// File: rtl/core/matrix_add_sub_multiply.sv
// Top level of the matrix engine: command port, register file, element sequencer,
// multiply/accumulate pipeline and result register. Depends on mas_pkg and mas_store.
//
//   channel   ports                                    handshake
//   req       req_op, req_row, req_col, req_value      start & !busy
//   rsp       rsp_out_row, rsp_out_col, rsp_out_value,  rsp_valid, one cycle, no stall
//             rsp_last
//   csr       csr_index, csr_wdata                     csr_we
//
// A load beat writes its store directly and busy stays low. A sum or difference
// issues one element per cycle (rows_a * inner_dim elements); a product issues one
// A/B pair per cycle (rows_a * cols_b * inner_dim pairs), set by the single read port
// of each store. Results pass the store read, term and result registers; busy holds
// until the final result is out. Reset is synchronous and leaves both stores reading
// zero, with no clearing pass. The receiver cannot stall the result strobe.
`timescale 1ns / 1ps
`default_nettype none

module matrix_add_sub_multiply
   import mas_pkg::*;
(
   input  wire  logic                        clock,
   input  wire  logic                        reset,
   input  wire  logic                        start,
   output logic                              busy,
   input  wire  logic        [OP_W-1:0]      req_op,
   input  wire  logic        [IDX_W-1:0]     req_row,
   input  wire  logic        [IDX_W-1:0]     req_col,
   input  wire  logic signed [DATA_W-1:0]    req_value,
   output logic                              rsp_valid,
   output logic              [IDX_W-1:0]     rsp_out_row,
   output logic              [IDX_W-1:0]     rsp_out_col,
   output logic signed       [VALUE_W-1:0]   rsp_out_value,
   output logic                              rsp_last,
   input  wire  logic                        csr_we,
   input  wire  logic        [CSR_IDX_W-1:0] csr_index,
   input  wire  logic        [DIM_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [OP_W-1:0]  op;
      logic             first;
      logic             last_k;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last_elem;
   } tag_type;

   // registers
   logic [DIM_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   state_type        state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   tag_type          s1_ff, s1_in, s2_ff;
   logic signed [TERM_W-1:0]  term_ff, term_in;
   logic signed [VALUE_W-1:0] acc_ff, acc_in;
   logic                      rsp_valid_ff;
   logic [IDX_W-1:0]          rsp_row_ff, rsp_col_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;

   // sequencer signals
   logic             accept, is_prod, last_k, last_j, last_i, running;
   logic [DIM_W-1:0] nr, nk, nc, width;
   logic [IDX_W-1:0] nr_m1, nk_m1, w_m1;
   logic [ADDR_W-1:0] a_rd_addr, b_rd_addr;
   store_wr_type     a_wr, b_wr;
   logic signed [DATA_W-1:0] a_data, b_data;
   logic signed [DATA_W:0]   pair_sum;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_W'(1);
         inner_dim_ff <= DIM_W'(1);
         cols_b_ff    <= DIM_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_ROWS_A:    rows_a_ff    <= csr_wdata;
            REG_INNER_DIM: inner_dim_ff <= csr_wdata;
            REG_COLS_B:    cols_b_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign nr      = dim_of(rows_a_ff);
   assign nk      = dim_of(inner_dim_ff);
   assign nc      = dim_of(cols_b_ff);
   assign is_prod = (op_ff == OP_PROD);
   assign width   = is_prod ? nc : nk;
   assign nr_m1   = IDX_W'(nr - DIM_W'(1));
   assign nk_m1   = IDX_W'(nk - DIM_W'(1));
   assign w_m1    = IDX_W'(width - DIM_W'(1));
   assign running = (state_ff == ST_RUN);
   assign last_k  = !is_prod || (k_ff == nk_m1);
   assign last_j  = (j_ff == w_m1);
   assign last_i  = (i_ff == nr_m1);

   // row and col are three bits wide, so every load lands inside the store
   always_comb begin
      a_wr.en   = accept && (req_op == OP_LOAD_A);
      a_wr.addr = {req_row, req_col};
      a_wr.data = req_value;
      b_wr.en   = accept && (req_op == OP_LOAD_B);
      b_wr.addr = {req_row, req_col};
      b_wr.data = req_value;
   end

   assign a_rd_addr = is_prod ? {i_ff, k_ff} : {i_ff, j_ff};
   assign b_rd_addr = is_prod ? {k_ff, j_ff} : {i_ff, j_ff};

   mas_store u_store_a (
      .clock   (clock),
      .reset   (reset),
      .wr      (a_wr),
      .rd_addr (a_rd_addr),
      .rd_data (a_data)
   );

   mas_store u_store_b (
      .clock   (clock),
      .reset   (reset),
      .wr      (b_wr),
      .rd_addr (b_rd_addr),
      .rd_data (b_data)
   );

   // walk rows, then columns, then the dot-product index
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op inside {OP_SUM, OP_DIFF, OP_PROD})) begin
               state_in = ST_RUN;
               op_in    = req_op;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (last_k) begin
               k_in = '0;
               if (last_j) begin
                  j_in = '0;
                  if (last_i) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                  end
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      s1_in.valid     = running;
      s1_in.op        = op_ff;
      s1_in.first     = !is_prod || (k_ff == '0);
      s1_in.last_k    = last_k;
      s1_in.row       = i_ff;
      s1_in.col       = j_ff;
      s1_in.last_elem = last_i && last_j;
   end

   // read data lines up with the tag in the cycle after issue
   always_comb begin
      pair_sum = (s1_ff.op == OP_DIFF) ? (DATA_W+1)'(a_data) - (DATA_W+1)'(b_data)
                                       : (DATA_W+1)'(a_data) + (DATA_W+1)'(b_data);
      if (s1_ff.op == OP_PROD) begin
         term_in = TERM_W'(a_data) * TERM_W'(b_data);
      end else begin
         term_in = TERM_W'(pair_sum) <<< 8;
      end
   end

   assign acc_in = (s2_ff.first ? '0 : acc_ff) + VALUE_W'(term_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SUM;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         s1_ff        <= s1_in;
         s2_ff        <= s1_ff;
         rsp_valid_ff <= s2_ff.valid && s2_ff.last_k;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      acc_ff  <= acc_in;
      if (s2_ff.valid && s2_ff.last_k) begin
         rsp_row_ff   <= s2_ff.row;
         rsp_col_ff   <= s2_ff.col;
         rsp_value_ff <= acc_in;
         rsp_last_ff  <= s2_ff.last_elem;
      end
   end

   assign busy          = running || s1_ff.valid || s2_ff.valid;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

   a_rsp_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without work in flight");

   a_compute_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_SUM || req_op == OP_DIFF || req_op == OP_PROD)) |=> busy)
      else $error("compute beat did not raise busy");

   a_last_ends_work: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("work still in flight after final result");

   a_load_keeps_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_LOAD_A || req_op == OP_LOAD_B)) |=> !busy)
      else $error("load beat raised busy");

endmodule

`default_nettype wire
